### design/lsda_pkg.sv
// ----------------------------------------------------------------------------
// lsda_pkg
// Types, codes and constants shared by the laser spot detector with autorange.
// ----------------------------------------------------------------------------
package lsda_pkg;

    localparam int DETECTOR_WINDOW_DEF = 8;
    localparam int AMBIENT_WINDOW_DEF  = 8;

    localparam int SAMPLE_W   = 10;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_AMB_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DROP_LOW  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DROP_HIGH = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE    = 2'd3;

    localparam logic [9:0]         AMB_LIMIT_RST = 10'd50;
    localparam logic signed [10:0] DROP_LOW_RST  = 11'sd20;
    localparam logic signed [10:0] DROP_HIGH_RST = 11'sd400;
    localparam logic [15:0]        SETTLE_RST    = 16'd100;

    localparam logic [4:0] GAIN_MAX  = 5'd31;
    localparam logic [4:0] GAIN_MIN  = 5'd0;
    localparam logic [9:0] AVG_LOW   = 10'd200;
    localparam logic [9:0] AVG_HIGH  = 10'd900;
    localparam logic [9:0] BIAS_STEP = 10'd100;

    typedef enum logic [2:0] {
        PH_INIT     = 3'd0,
        PH_SAMPLE   = 3'd1,
        PH_ADJUST   = 3'd2,
        PH_RESAMPLE = 3'd3,
        PH_SETTLE   = 3'd4,
        PH_DETECT   = 3'd5,
        PH_DETECTED = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        BIAS_NONE = 2'd0,
        BIAS_UP   = 2'd1,
        BIAS_DOWN = 2'd2
    } bias_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_DIV,
        ST_DECIDE
    } ctl_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] detector_sample;
        logic [SAMPLE_W-1:0] ambient_sample;
    } lsda_in_t;

    typedef struct packed {
        logic [2:0]          phase;
        logic [4:0]          gain_step;
        logic                laser_found;
        logic [SAMPLE_W-1:0] detector_average;
        logic                settling;
    } lsda_out_t;

    function automatic logic [9:0] thr_low(input bias_t b);
        unique case (b)
            BIAS_UP:   return AVG_LOW + BIAS_STEP;
            BIAS_DOWN: return AVG_LOW - BIAS_STEP;
            default:   return AVG_LOW;
        endcase
    endfunction

    function automatic logic [9:0] thr_high(input bias_t b);
        unique case (b)
            BIAS_UP:   return AVG_HIGH + BIAS_STEP;
            BIAS_DOWN: return AVG_HIGH - BIAS_STEP;
            default:   return AVG_HIGH;
        endcase
    endfunction

endpackage

### design/lsda_ram.sv
// ----------------------------------------------------------------------------
// lsda_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module lsda_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/laser_spot_detector_autorange_unit.sv
// ----------------------------------------------------------------------------
// laser_spot_detector_autorange_unit
// Laser spot detector with moving-average channels and gain autorange.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per converter tick, a detector and an ambient sample.
//   m_ channel: one item per accepted input item: phase, gain step, sticky
//   found flag, detector average and settling flag, all after the tick.
//   cfg_ port: write-only registers, to be written while the block is idle; the block does not enforce this.
// Flow:
//   a tick in the init (once started), sample or resample phase goes through
//   the window RAMs and the per-channel restoring dividers: read, accumulate,
//   divide, then decide. Ticks in other phases go from accept straight to the
//   decide step. The dividers give one quotient bit per cycle.
//   One item is in work at a time; s_ready is high only while idle.
// Reset:
//   aresetn low clears phase, gain, counters and channel state, and loads the
//   register defaults. Window RAM content is tracked by fill counts, so no
//   clearing pass is needed.
// Stall:
//   a result waits in the output register; the next item may be accepted
//   meanwhile, and its result is held back until the register is free.
// ----------------------------------------------------------------------------
module laser_spot_detector_autorange_unit
    import lsda_pkg::*;
#(
    parameter int DETECTOR_WINDOW = DETECTOR_WINDOW_DEF,
    parameter int AMBIENT_WINDOW  = AMBIENT_WINDOW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lsda_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lsda_out_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int MAX_W = (DETECTOR_WINDOW > AMBIENT_WINDOW) ? DETECTOR_WINDOW
                                                              : AMBIENT_WINDOW;
    localparam int CNT_W = $clog2(MAX_W + 1);
    localparam int PTR_W = $clog2(MAX_W);
    localparam int SUM_W = $clog2(MAX_W * 1023 + 1);
    localparam int DC_W  = $clog2(SUM_W);
    localparam int DA_W  = $clog2(DETECTOR_WINDOW);
    localparam int AA_W  = $clog2(AMBIENT_WINDOW);

    function automatic logic [CNT_W-1:0] chan_len(input int c);
        return (c == 0) ? CNT_W'(DETECTOR_WINDOW) : CNT_W'(AMBIENT_WINDOW);
    endfunction

    // configuration
    logic [9:0]         amb_limit_reg;
    logic signed [10:0] drop_low_reg;
    logic signed [10:0] drop_high_reg;
    logic [15:0]        settle_ticks_reg;

    // block state
    phase_t      phase_reg, phase_next;
    logic        init_done_reg, init_done_next;
    logic [15:0] settle_cnt_reg, settle_cnt_next;
    logic [4:0]  gain_reg, gain_next;
    bias_t       bias_reg, bias_next;

    // channel state, 0 detector, 1 ambient
    logic [CNT_W-1:0]    fill_reg [2];
    logic [CNT_W-1:0]    fill_next [2];
    logic [PTR_W-1:0]    ptr_reg [2];
    logic [PTR_W-1:0]    ptr_next [2];
    logic [SUM_W-1:0]    sum_reg [2];
    logic [SUM_W-1:0]    sum_next [2];
    logic [SAMPLE_W-1:0] avg_reg [2];
    logic [SAMPLE_W-1:0] avg_next [2];
    logic [SAMPLE_W-1:0] ref_reg [2];
    logic [SAMPLE_W-1:0] ref_next [2];

    // per-item working registers
    ctl_state_t          st_reg, st_next;
    logic [SAMPLE_W-1:0] smp_reg [2];
    logic                sampled_reg;
    logic                full_reg [2];
    logic                full_next [2];
    logic                ref_upd_reg [2];
    logic                ref_upd_next [2];
    logic [SUM_W-1:0]    dvd_reg [2];
    logic [SUM_W-1:0]    dvd_next [2];
    logic [CNT_W-1:0]    rem_reg [2];
    logic [CNT_W-1:0]    rem_next [2];
    logic [CNT_W-1:0]    dvs_reg [2];
    logic [CNT_W-1:0]    dvs_next [2];
    logic [DC_W-1:0]     div_cnt_reg, div_cnt_next;

    logic                m_valid_reg;
    lsda_out_t           m_data_reg;

    logic                out_free;
    logic                samp_now;
    logic                ram_rd_en;
    logic                ram_wr_en;
    logic                upd;
    // channels are cleared by the first init tick and by a gain change
    logic                clr;
    logic [SAMPLE_W-1:0] rd_data [2];

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // this tick goes through the windows
    always_comb begin
        unique case (phase_reg)
            PH_SAMPLE, PH_RESAMPLE:                      samp_now = 1'b1;
            PH_ADJUST, PH_SETTLE, PH_DETECT, PH_DETECTED: samp_now = 1'b0;
            default:                                     samp_now = init_done_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // window memories
    // ------------------------------------------------------------------
    lsda_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DETECTOR_WINDOW)
    ) u_det_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg[0][DA_W-1:0]),
        .wr_data (smp_reg[0]),
        .rd_en   (ram_rd_en),
        .rd_addr (ptr_reg[0][DA_W-1:0]),
        .rd_data (rd_data[0])
    );

    lsda_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (AMBIENT_WINDOW)
    ) u_amb_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg[1][AA_W-1:0]),
        .wr_data (smp_reg[1]),
        .rd_en   (ram_rd_en),
        .rd_addr (ptr_reg[1][AA_W-1:0]),
        .rd_data (rd_data[1])
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    st_next = samp_now ? ST_READ : ST_DECIDE;
                end
            end
            ST_READ:  st_next = ST_ACCUM;
            ST_ACCUM: st_next = ST_DIV;
            ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    st_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        upd       = 1'b0;
        unique case (st_reg)
            ST_IDLE:   s_ready   = 1'b1;
            ST_READ:   ram_rd_en = 1'b1;
            ST_ACCUM:  ram_wr_en = 1'b1;
            ST_DECIDE: upd       = out_free;
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // channel update and divider
    // ------------------------------------------------------------------
    always_comb begin
        logic                full_now;
        logic [CNT_W-1:0]    len;
        logic [CNT_W:0]      shifted;
        logic                qbit;
        for (int c = 0; c < 2; c++) begin
            fill_next[c]    = fill_reg[c];
            ptr_next[c]     = ptr_reg[c];
            sum_next[c]     = sum_reg[c];
            full_next[c]    = full_reg[c];
            ref_upd_next[c] = ref_upd_reg[c];
            dvd_next[c]     = dvd_reg[c];
            rem_next[c]     = rem_reg[c];
            dvs_next[c]     = dvs_reg[c];
            len             = chan_len(c);
            full_now        = (fill_reg[c] == len);
            shifted         = {rem_reg[c], dvd_reg[c][SUM_W-1]};
            qbit            = (shifted >= {1'b0, dvs_reg[c]});
            if (st_reg == ST_ACCUM) begin
                // full window drops its oldest entry, which sits at the pointer
                sum_next[c] = sum_reg[c] + SUM_W'(smp_reg[c])
                            - (full_now ? SUM_W'(rd_data[c]) : SUM_W'(0));
                fill_next[c]    = full_now ? len : fill_reg[c] + 1'b1;
                full_next[c]    = full_now || (fill_reg[c] + 1'b1 == len);
                ref_upd_next[c] = !(full_now || (fill_reg[c] + 1'b1 == len));
                ptr_next[c]     = (ptr_reg[c] == PTR_W'(len - 1'b1))
                                ? '0 : ptr_reg[c] + 1'b1;
                dvd_next[c]     = sum_next[c];
                rem_next[c]     = '0;
                dvs_next[c]     = fill_next[c];
            end else if (st_reg == ST_DIV) begin
                rem_next[c] = qbit ? CNT_W'(shifted - {1'b0, dvs_reg[c]})
                                   : shifted[CNT_W-1:0];
                dvd_next[c] = {dvd_reg[c][SUM_W-2:0], qbit};
            end
        end
    end

    always_comb begin
        div_cnt_next = div_cnt_reg;
        if (st_reg == ST_ACCUM) begin
            div_cnt_next = DC_W'(SUM_W - 1);
        end else if (st_reg == ST_DIV) begin
            div_cnt_next = div_cnt_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // phase decisions
    // ------------------------------------------------------------------
    always_comb begin
        logic               both_full;
        logic [9:0]         lo_thr;
        logic [9:0]         hi_thr;
        logic               go_up;
        logic               go_down;
        logic signed [10:0] amb_diff;
        logic [9:0]         damb;
        logic               rebase;
        logic [9:0]         ref0_eff;
        logic signed [10:0] ddet;

        phase_next     = phase_reg;
        init_done_next = init_done_reg;
        settle_cnt_next = settle_cnt_reg;
        gain_next      = gain_reg;
        bias_next      = bias_reg;
        clr            = 1'b0;
        for (int c = 0; c < 2; c++) begin
            avg_next[c] = avg_reg[c];
            ref_next[c] = ref_reg[c];
            if (upd && sampled_reg) begin
                avg_next[c] = dvd_reg[c][SAMPLE_W-1:0];
                if (ref_upd_reg[c]) begin
                    ref_next[c] = dvd_reg[c][SAMPLE_W-1:0];
                end
            end
        end

        both_full = full_reg[0] && full_reg[1];
        lo_thr    = thr_low(bias_reg);
        hi_thr    = thr_high(bias_reg);
        go_up     = (avg_next[0] < lo_thr) && (gain_reg != GAIN_MAX);
        go_down   = (avg_next[0] > hi_thr) && (gain_reg != GAIN_MIN);

        amb_diff = $signed({1'b0, ref_reg[1]}) - $signed({1'b0, avg_reg[1]});
        damb     = amb_diff[10] ? 10'(-amb_diff) : amb_diff[9:0];
        rebase   = (damb > amb_limit_reg);
        ref0_eff = rebase ? avg_reg[0] : ref_reg[0];
        ddet     = $signed({1'b0, ref0_eff}) - $signed({1'b0, avg_reg[0]});

        if (upd) begin
            unique case (phase_reg)
                PH_SAMPLE: begin
                    if (both_full) begin
                        phase_next = (go_up || go_down) ? PH_ADJUST : PH_DETECT;
                    end
                end
                PH_ADJUST: begin
                    clr = 1'b1;
                    if (bias_reg == BIAS_NONE) begin
                        gain_next = GAIN_MIN;
                        bias_next = BIAS_UP;
                    end else if (go_down) begin
                        gain_next = gain_reg - 1'b1;
                        bias_next = BIAS_DOWN;
                    end else if (go_up) begin
                        gain_next = gain_reg + 1'b1;
                        bias_next = BIAS_UP;
                    end else begin
                        clr = 1'b0;
                    end
                    if (clr) begin
                        settle_cnt_next = '0;
                        phase_next      = PH_SETTLE;
                    end else begin
                        phase_next = PH_SAMPLE;
                    end
                end
                PH_RESAMPLE: begin
                    if (both_full) begin
                        phase_next = PH_ADJUST;
                    end
                end
                PH_SETTLE: begin
                    if (settle_cnt_reg == settle_ticks_reg) begin
                        phase_next      = PH_RESAMPLE;
                        settle_cnt_next = settle_cnt_reg + 1'b1;
                    end else if (settle_cnt_reg > settle_ticks_reg) begin
                        settle_cnt_next = 16'd1;
                    end else begin
                        settle_cnt_next = settle_cnt_reg + 1'b1;
                    end
                end
                PH_DETECT: begin
                    if (rebase) begin
                        ref_next[0] = avg_reg[0];
                        ref_next[1] = avg_reg[1];
                    end
                    // after a rebase the ambient change counts as zero
                    if (ddet > drop_low_reg && ddet < drop_high_reg &&
                        (rebase ? (amb_limit_reg != '0) : (damb < amb_limit_reg))) begin
                        phase_next = PH_DETECTED;
                    end else begin
                        phase_next = PH_SAMPLE;
                    end
                end
                PH_DETECTED: begin
                end
                default: begin
                    if (!init_done_reg) begin
                        clr            = 1'b1;
                        init_done_next = 1'b1;
                        phase_next     = PH_INIT;
                    end else if (both_full) begin
                        phase_next = PH_ADJUST;
                    end else begin
                        phase_next = PH_INIT;
                    end
                end
            endcase
        end

        if (clr) begin
            for (int c = 0; c < 2; c++) begin
                avg_next[c] = '0;
                ref_next[c] = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amb_limit_reg    <= AMB_LIMIT_RST;
            drop_low_reg     <= DROP_LOW_RST;
            drop_high_reg    <= DROP_HIGH_RST;
            settle_ticks_reg <= SETTLE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_AMB_LIMIT: amb_limit_reg    <= cfg_wdata[9:0];
                REG_DROP_LOW:  drop_low_reg     <= $signed(cfg_wdata[10:0]);
                REG_DROP_HIGH: drop_high_reg    <= $signed(cfg_wdata[10:0]);
                REG_SETTLE:    settle_ticks_reg <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            phase_reg      <= PH_INIT;
            init_done_reg  <= 1'b0;
            settle_cnt_reg <= '0;
            gain_reg       <= '0;
            bias_reg       <= BIAS_NONE;
            m_valid_reg    <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                fill_reg[c] <= '0;
                ptr_reg[c]  <= '0;
                sum_reg[c]  <= '0;
                avg_reg[c]  <= '0;
                ref_reg[c]  <= '0;
            end
        end else begin
            st_reg         <= st_next;
            phase_reg      <= phase_next;
            init_done_reg  <= init_done_next;
            settle_cnt_reg <= settle_cnt_next;
            gain_reg       <= gain_next;
            bias_reg       <= bias_next;
            if (upd) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            for (int c = 0; c < 2; c++) begin
                avg_reg[c] <= avg_next[c];
                ref_reg[c] <= ref_next[c];
                if (clr) begin
                    fill_reg[c] <= '0;
                    ptr_reg[c]  <= '0;
                    sum_reg[c]  <= '0;
                end else begin
                    fill_reg[c] <= fill_next[c];
                    ptr_reg[c]  <= ptr_next[c];
                    sum_reg[c]  <= sum_next[c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && s_valid) begin
            smp_reg[0]  <= s_data.detector_sample;
            smp_reg[1]  <= s_data.ambient_sample;
            sampled_reg <= samp_now;
        end
        for (int c = 0; c < 2; c++) begin
            full_reg[c]    <= full_next[c];
            ref_upd_reg[c] <= ref_upd_next[c];
            dvd_reg[c]     <= dvd_next[c];
            rem_reg[c]     <= rem_next[c];
            dvs_reg[c]     <= dvs_next[c];
        end
        div_cnt_reg <= div_cnt_next;
        if (upd) begin
            m_data_reg.phase            <= phase_next;
            m_data_reg.gain_step        <= gain_next;
            m_data_reg.laser_found      <= (phase_next == PH_DETECTED);
            m_data_reg.detector_average <= avg_next[0];
            m_data_reg.settling         <= (phase_next == PH_SETTLE);
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg[0] <= CNT_W'(DETECTOR_WINDOW) && fill_reg[1] <= CNT_W'(AMBIENT_WINDOW))
        else $error("window fill count beyond window length");

    a_ptr_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg[0] < CNT_W'(DETECTOR_WINDOW) |-> CNT_W'(ptr_reg[0]) == fill_reg[0])
        else $error("detector write pointer out of step with fill count");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DECIDE && out_free) |=> m_valid_reg)
        else $error("finished item did not reach the output register");

    a_div_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_DIV |=> (st_reg == ST_DIV || st_reg == ST_DECIDE))
        else $error("divider left early");

    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DETECTED |=> phase_reg == PH_DETECTED)
        else $error("detected phase was left");
`endif

endmodule

### test/lsda_tick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsda_tick_checker
// Watches the sample, report and register ports of the laser spot detector,
// tracks the detector state for every accepted tick and compares each report
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module lsda_tick_checker
    import lsda_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  lsda_in_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  lsda_out_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    mismatch_count,
    output int                    reports_pending
);

    localparam int DET_N = DETECTOR_WINDOW_DEF;
    localparam int AMB_N = AMBIENT_WINDOW_DEF;

    // register copies
    logic [9:0]         amb_limit;
    logic signed [10:0] drop_lo;
    logic signed [10:0] drop_hi;
    logic [15:0]        settle_lim;

    // tracked detector state, channel 0 is the detector and 1 the ambient
    phase_t      ph;
    bit          init_done;
    logic [15:0] settle_cnt;
    logic [4:0]  gain;
    bias_t       bias;
    logic [9:0]  win_mem [2][64];
    logic [7:0]  fill [2];
    logic [13:0] sums [2];
    logic [9:0]  avgs [2];
    logic [9:0]  refs [2];

    lsda_out_t reports_due [$];

    task automatic clear_channels();
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < 64; i++) win_mem[c][i] = '0;
            fill[c] = '0;
            sums[c] = '0;
            avgs[c] = '0;
            refs[c] = '0;
        end
    endtask

    task automatic push_sample(input int c, input logic [9:0] s, output bit full);
        int n;
        int len;
        n = fill[c];
        len = (c == 0) ? DET_N : AMB_N;
        if (n >= len) begin
            sums[c] = sums[c] - win_mem[c][0];
            for (int i = 1; i < len; i++) win_mem[c][i-1] = win_mem[c][i];
            win_mem[c][len-1] = s;
            sums[c] = sums[c] + s;
            fill[c] = 8'(len);
            avgs[c] = 10'(int'(sums[c]) / len);
            full = 1'b1;
        end else begin
            // the completing sample lands in the last slot, no shift
            win_mem[c][n] = s;
            sums[c] = sums[c] + s;
            n++;
            fill[c] = 8'(n);
            avgs[c] = 10'(int'(sums[c]) / n);
            if (n < len) begin
                refs[c] = avgs[c];
                full = 1'b0;
            end else begin
                full = 1'b1;
            end
        end
    endtask

    task automatic sample_both(input lsda_in_t it, output bit full);
        bit det_full;
        bit amb_full;
        push_sample(0, it.detector_sample, det_full);
        push_sample(1, it.ambient_sample, amb_full);
        full = det_full && amb_full;
    endtask

    function automatic int bias_offset(input bias_t b);
        case (b)
            BIAS_UP:   return int'(BIAS_STEP);
            BIAS_DOWN: return -int'(BIAS_STEP);
            default:   return 0;
        endcase
    endfunction

    task automatic track_tick(input lsda_in_t it, output lsda_out_t rpt);
        bit full;
        int davg;
        int lo_thr;
        int hi_thr;
        int damb;
        int ddet;
        davg = int'(avgs[0]);
        lo_thr = int'(AVG_LOW) + bias_offset(bias);
        hi_thr = int'(AVG_HIGH) + bias_offset(bias);
        case (ph)
            PH_SAMPLE: begin
                sample_both(it, full);
                if (full) begin
                    davg = int'(avgs[0]);
                    if ((davg < lo_thr && gain != GAIN_MAX) ||
                        (davg > hi_thr && gain != GAIN_MIN))
                        ph = PH_ADJUST;
                    else
                        ph = PH_DETECT;
                end
            end
            PH_ADJUST: begin
                full = 1'b1;
                if (bias == BIAS_NONE) begin
                    gain = GAIN_MIN;
                    bias = BIAS_UP;
                end else if (davg > hi_thr && gain != GAIN_MIN) begin
                    gain = gain - 5'd1;
                    bias = BIAS_DOWN;
                end else if (davg < lo_thr && gain != GAIN_MAX) begin
                    gain = gain + 5'd1;
                    bias = BIAS_UP;
                end else begin
                    full = 1'b0;
                end
                // full doubles here as "gain moved"
                if (full) begin
                    clear_channels();
                    settle_cnt = '0;
                    ph = PH_SETTLE;
                end else begin
                    ph = PH_SAMPLE;
                end
            end
            PH_RESAMPLE: begin
                sample_both(it, full);
                if (full) ph = PH_ADJUST;
            end
            PH_SETTLE: begin
                if (settle_cnt == settle_lim)
                    ph = PH_RESAMPLE;
                else if (settle_cnt > settle_lim)
                    settle_cnt = '0;
                settle_cnt = settle_cnt + 16'd1;
            end
            PH_DETECT: begin
                damb = int'(refs[1]) - int'(avgs[1]);
                if (damb < 0) damb = -damb;
                if (damb > int'(amb_limit)) begin
                    // ambient moved too far, rebase both references
                    refs[1] = avgs[1];
                    refs[0] = avgs[0];
                    damb = 0;
                end
                ddet = int'(refs[0]) - int'(avgs[0]);
                if (ddet > int'(drop_lo) && ddet < int'(drop_hi) && damb < int'(amb_limit))
                    ph = PH_DETECTED;
                else
                    ph = PH_SAMPLE;
            end
            PH_DETECTED: begin
            end
            default: begin
                if (!init_done) begin
                    // first init tick only clears, no sample taken
                    clear_channels();
                    init_done = 1'b1;
                    ph = PH_INIT;
                end else begin
                    sample_both(it, full);
                    ph = full ? PH_ADJUST : PH_INIT;
                end
            end
        endcase
        rpt.phase            = ph;
        rpt.gain_step        = gain;
        rpt.laser_found      = (ph == PH_DETECTED);
        rpt.detector_average = avgs[0];
        rpt.settling         = (ph == PH_SETTLE);
    endtask

    always @(posedge aclk) begin
        lsda_out_t due;
        lsda_out_t got;
        if (!aresetn) begin
            amb_limit  = AMB_LIMIT_RST;
            drop_lo    = DROP_LOW_RST;
            drop_hi    = DROP_HIGH_RST;
            settle_lim = SETTLE_RST;
            ph         = PH_INIT;
            init_done  = 1'b0;
            settle_cnt = '0;
            gain       = GAIN_MIN;
            bias       = BIAS_NONE;
            clear_channels();
            reports_due.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_AMB_LIMIT: amb_limit  = cfg_wdata[9:0];
                    REG_DROP_LOW:  drop_lo    = cfg_wdata[10:0];
                    REG_DROP_HIGH: drop_hi    = cfg_wdata[10:0];
                    REG_SETTLE:    settle_lim = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // check the report before queueing this edge's item
            if (m_valid && m_ready) begin
                got = m_data;
                if (reports_due.size() == 0) begin
                    mismatch_count++;
                    $display({"%0t: unexpected report, expected none, got phase %0d",
                              " gain %0d found %0b avg %0d settling %0b"},
                             $time, got.phase, got.gain_step, got.laser_found,
                             got.detector_average, got.settling);
                end else begin
                    due = reports_due.pop_front();
                    if (got.phase !== due.phase || got.gain_step !== due.gain_step ||
                        got.laser_found !== due.laser_found ||
                        got.detector_average !== due.detector_average ||
                        got.settling !== due.settling) begin
                        mismatch_count++;
                        $display({"%0t: report mismatch, expected phase %0d gain %0d found %0b",
                                  " avg %0d settling %0b, got phase %0d gain %0d found %0b",
                                  " avg %0d settling %0b"},
                                 $time, due.phase, due.gain_step, due.laser_found,
                                 due.detector_average, due.settling, got.phase,
                                 got.gain_step, got.laser_found, got.detector_average,
                                 got.settling);
                    end
                end
            end
            if (s_valid && s_ready) begin
                track_tick(s_data, due);
                reports_due.push_back(due);
            end
        end
        reports_pending = reports_due.size();
    end

endmodule

### test/laser_spot_detector_autorange_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_spot_detector_autorange_unit_tb
// Drives detector and ambient ticks through the autorange spot detector:
// a directed walk through init, adjust, settle and resample, then scenes of
// low, high and mid light with dips, ambient steps and noise under changing
// register settings, ending with a laser hit. Reports are checked by
// lsda_tick_checker.
// ----------------------------------------------------------------------------
module laser_spot_detector_autorange_unit_tb;
    import lsda_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    lsda_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    lsda_out_t             m_data;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    int mismatch_count;
    int reports_pending;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int quiet_cycles = 0;

    laser_spot_detector_autorange_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    lsda_tick_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic logic [9:0] clip10(input int v);
        if (v < 0) return 10'd0;
        if (v > 1023) return 10'd1023;
        return 10'(v);
    endfunction

    function automatic int wobble(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // entered and left just after a falling edge
    task automatic send_tick(input logic [9:0] det, input logic [9:0] amb);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= '{detector_sample: det, ambient_sample: amb};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic load_regs(input int lim, input int lo, input int hi, input int st);
        s_valid <= 1'b0;
        while (reports_pending != 0) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_AMB_LIMIT;
        cfg_wdata <= 16'(lim);
        @(negedge aclk);
        cfg_addr  <= REG_DROP_LOW;
        cfg_wdata <= 16'(lo);
        @(negedge aclk);
        cfg_addr  <= REG_DROP_HIGH;
        cfg_wdata <= 16'(hi);
        @(negedge aclk);
        cfg_addr  <= REG_SETTLE;
        cfg_wdata <= 16'(st);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // random settings that keep detection out of reach (drop_high <= drop_low)
    task automatic shuffle_regs();
        int lim;
        int lo;
        int hi;
        int st;
        case ($urandom_range(4))
            0: begin lo = 1023;  hi = -1024; end
            1: begin lo = -1024; hi = -1024; end
            2: begin lo = 1023;  hi = 1023;  end
            default: begin
                lo = int'($urandom_range(2047)) - 1024;
                hi = lo - int'($urandom_range(lo + 1024));
            end
        endcase
        case ($urandom_range(5))
            0: lim = 0;
            1: lim = 1023;
            default: lim = $urandom_range(120);
        endcase
        st = ($urandom_range(99) < 15) ? $urandom_range(40, 10) : $urandom_range(6);
        load_regs(lim, lo, hi, st);
    endtask

    task automatic play_scene(input int count);
        int kind;
        int det_lvl;
        int amb_lvl;
        int jitter;
        int det_dip;
        int amb_step;
        int turn;
        kind = $urandom_range(99);
        det_dip = 0;
        amb_step = 0;
        jitter = 20;
        turn = count / 2;
        amb_lvl = $urandom_range(1023);
        if (kind < 20) begin
            det_lvl = $urandom_range(150);
        end else if (kind < 35) begin
            det_lvl = $urandom_range(1023, 920);
        end else begin
            // mid light: the detect loop, with dips and ambient steps
            det_lvl = $urandom_range(800, 300);
            jitter = 8;
            if ($urandom_range(99) < 40) det_dip = $urandom_range(350, 30);
            if ($urandom_range(99) < 30)
                amb_step = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(400, 60));
        end
        for (int i = 0; i < count; i++) begin
            if (kind >= 82)
                send_tick(10'($urandom), 10'($urandom));
            else
                send_tick(clip10(det_lvl - (i >= turn ? det_dip : 0) + wobble(jitter)),
                          clip10(amb_lvl + (i >= turn ? amb_step : 0) + wobble(5)));
        end
    endtask

    initial begin
        int budget;
        int scene_len;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_AMB_LIMIT;
        cfg_wdata = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // no detection possible, no settle wait
        load_regs(1023, 1023, -1024, 0);
        // init: clearing tick, then eight samples filling both windows
        send_tick(10'd1023, 10'd0);
        send_tick(10'd0, 10'd1023);      send_tick(10'd1023, 10'd0);
        send_tick(10'h155, 10'h2aa);     send_tick(10'h2aa, 10'h155);
        send_tick(10'd1, 10'd1022);      send_tick(10'd1022, 10'd1);
        send_tick(10'd512, 10'd511);     send_tick(10'd511, 10'd512);
        // first adjust: gain to zero, bias up
        send_tick(10'd512, 10'd512);
        send_tick(10'd0, 10'd1023);
        // dark resample pushes the gain up one step
        repeat (8) send_tick(10'd0, 10'd1023);
        send_tick(10'd300, 10'd300);
        // longest settle, then lower the limit below the running count
        load_regs(1023, 1023, -1024, 65535);
        repeat (6) send_tick(10'd300, 10'd300);
        load_regs(1023, 1023, -1024, 3);

        for (int stretch = 0; stretch < 3; stretch++) begin
            src_idle_pct  = (stretch == 0) ? 14 : (stretch == 1) ? 85 : 0;
            sink_idle_pct = (stretch == 0) ? 85 : (stretch == 1) ? 14 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                if (stretch != 0 || blk != 0) shuffle_regs();
                budget = (stretch == 2 && blk == 2) ? 80 : 200;
                while (budget > 0) begin
                    scene_len = ($urandom_range(99) < 10) ? $urandom_range(300, 120)
                                                          : $urandom_range(60, 10);
                    if (scene_len > budget) scene_len = budget;
                    play_scene(scene_len);
                    budget -= scene_len;
                end
            end
        end

        // finally a steady spot, then a dip under stable ambient: sticky hit
        load_regs(AMB_LIMIT_RST, DROP_LOW_RST, DROP_HIGH_RST, 2);
        for (int i = 0; i < 120; i++)
            send_tick(clip10(520 - (i >= 60 ? 120 : 0) + wobble(4)), clip10(300 + wobble(3)));

        s_valid <= 1'b0;
        while (reports_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && reports_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
